>>> hdl/glos_pkg.sv
package glos_pkg;

  localparam int GridWidth  = 64;
  localparam int GridHeight = 64;
  localparam int CoordW     = 6;
  localparam int AddrW      = 12;
  localparam int QueueDepth = 2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic              blocked;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_SEND
  } back_state_t;

  // Unit-interval test on q/d without dividing.
  function automatic logic ratio_in_unit(input logic signed [15:0] q,
                                         input logic signed [15:0] d);
    logic r;
    if (d > 16'sd0) r = (q >= 16'sd0) && (q <= d);
    else            r = (q <= 16'sd0) && (q >= d);
    return r;
  endfunction

  // Segment P1-P2 against an axis-aligned edge A-B.
  function automatic logic meets_edge(
      input logic signed [8:0] p1x, input logic signed [8:0] p1y,
      input logic signed [8:0] p2x, input logic signed [8:0] p2y,
      input logic signed [8:0] ax,  input logic signed [8:0] ay,
      input logic signed [8:0] bx,  input logic signed [8:0] by);
    logic signed [15:0] d1x, d1y, d2x, d2y, d, q, q2, ex, ey;
    logic r;
    d1x = 16'(p2x) - 16'(p1x);
    d1y = 16'(p2y) - 16'(p1y);
    d2x = 16'(bx) - 16'(ax);
    d2y = 16'(by) - 16'(ay);
    ex  = 16'(p1x) - 16'(ax);
    ey  = 16'(p1y) - 16'(ay);
    d   = 16'(d1x * d2y - d1y * d2x);
    q   = 16'(ey * d2x - ex * d2y);
    q2  = 16'(ey * d1x - ex * d1y);
    if (d == 16'sd0) r = 1'b0;
    else             r = ratio_in_unit(q, d) && ratio_in_unit(q2, d);
    return r;
  endfunction

endpackage

>>> hdl/glos_front.sv
module glos_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  glos_pkg::job_t                in_job,
  output logic                          q_valid,
  input  logic                          q_take,
  output glos_pkg::job_t                q_job
);

  glos_pkg::job_t slot [glos_pkg::QueueDepth];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_job    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> hdl/glos_back.sv
module glos_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  glos_pkg::job_t q_job,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           sight_clear
);

  logic                    map_mem [glos_pkg::GridWidth*glos_pkg::GridHeight];
  logic [glos_pkg::AddrW:0] clr_idx;
  logic                    clearing;
  logic                    rd_bit;

  glos_pkg::back_state_t state, state_next;
  logic [glos_pkg::CoordW-1:0] x1, y0, y1, cx, cy;
  logic [glos_pkg::CoordW-1:0] fx, fy, tx, ty;
  logic          clear_r;
  logic          hit;
  logic          last_tile;
  logic          load;

  // Clearing sweep after reset: one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == (glos_pkg::AddrW+1)'(glos_pkg::GridWidth*glos_pkg::GridHeight-1))
        clearing <= 1'b0;
    end
  end

  logic                      wr_en;
  logic [glos_pkg::AddrW-1:0] wr_addr;
  logic                      wr_data;
  assign wr_en   = clearing || (state == glos_pkg::ST_IDLE && q_valid &&
                                q_job.command == glos_pkg::CMD_WRITE);
  assign wr_addr = clearing ? clr_idx[glos_pkg::AddrW-1:0] : {q_job.ay, q_job.ax};
  assign wr_data = clearing ? 1'b0 : q_job.blocked;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    rd_bit <= map_mem[{cy, cx}];
  end

  always_comb begin
    logic signed [8:0] p1x, p1y, p2x, p2y, lx, ly, rx, ry;
    p1x = 9'(2*fx + 1); p1y = 9'(2*fy + 1);
    p2x = 9'(2*tx + 1); p2y = 9'(2*ty + 1);
    lx  = 9'(2*cx);     ly  = 9'(2*cy);
    rx  = lx + 9'sd2;   ry  = ly + 9'sd2;
    hit = (p1x > lx && p1x < rx && p1y > ly && p1y < ry) ||
          (p2x > lx && p2x < rx && p2y > ly && p2y < ry) ||
          glos_pkg::meets_edge(p1x, p1y, p2x, p2y, lx, ly, rx, ly) ||
          glos_pkg::meets_edge(p1x, p1y, p2x, p2y, lx, ly, lx, ry) ||
          glos_pkg::meets_edge(p1x, p1y, p2x, p2y, rx, ry, rx, ly) ||
          glos_pkg::meets_edge(p1x, p1y, p2x, p2y, rx, ry, lx, ry);
  end

  assign last_tile = (cx == x1) && (cy == y1);
  assign load = (state == glos_pkg::ST_IDLE) && q_valid && !clearing &&
                q_job.command == glos_pkg::CMD_QUERY;

  always_comb begin
    state_next = state;
    unique case (state)
      glos_pkg::ST_IDLE: if (load) state_next = glos_pkg::ST_READ;
      glos_pkg::ST_READ: state_next = glos_pkg::ST_TEST;
      glos_pkg::ST_TEST: begin
        if ((rd_bit && hit) || last_tile) state_next = glos_pkg::ST_SEND;
        else                               state_next = glos_pkg::ST_READ;
      end
      glos_pkg::ST_SEND: if (!out_stall) state_next = glos_pkg::ST_IDLE;
      default: state_next = glos_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take    = (state == glos_pkg::ST_IDLE) && !clearing;
    out_valid = (state == glos_pkg::ST_SEND);
  end
  assign sight_clear = clear_r;

  always_ff @(posedge clk) begin
    if (rst) state <= glos_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fx <= q_job.ax; fy <= q_job.ay; tx <= q_job.bx; ty <= q_job.by;
      x1 <= (q_job.ax < q_job.bx) ? q_job.bx : q_job.ax;
      y0 <= (q_job.ay < q_job.by) ? q_job.ay : q_job.by;
      y1 <= (q_job.ay < q_job.by) ? q_job.by : q_job.ay;
      cx <= (q_job.ax < q_job.bx) ? q_job.ax : q_job.bx;
      cy <= (q_job.ay < q_job.by) ? q_job.ay : q_job.by;
      clear_r <= 1'b1;
    end else if (state == glos_pkg::ST_TEST) begin
      if (rd_bit && hit) clear_r <= 1'b0;
      if (cy == y1) begin
        cy <= y0;
        cx <= cx + 1'b1;
      end else begin
        cy <= cy + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) clearing |-> !q_take)
    else $error("item taken during clearing sweep");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(sight_clear))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == glos_pkg::ST_READ) |=> state == glos_pkg::ST_TEST)
    else $error("read not followed by test");

endmodule

>>> hdl/grid_line_of_sight.sv
// Line-of-sight engine over a 64x64 blocked/walkable tile bitmap.
// Input channel (in_valid/in_stall): one beat per command. A write beat
// (command 0) sets cell (cell_x, cell_y) and yields nothing. A query beat
// (command 1) yields one beat on the output channel (out_valid/out_stall)
// carrying sight_clear, 1 when no blocked tile of the bounding box touches
// the centre-to-centre segment.
// A two-entry queue parts the front from the back, so the front keeps
// taking beats while the back walks a query.
// Flow: an accepted beat is stored in the queue before the back sees it. A
// write is done as the back takes it; a query leaves the queue, then
// visits each tile of its bounding box with a memory read, then the edge
// test, stopping early at the first blocking tile, and then presents the
// result. The bitmap memory has a single read port.
// Reset: the bitmap is swept to walkable, one cell a cycle;
// beats queue up meanwhile but none is executed.
// When the receiver stalls, the result beat holds and the back waits;
// the front goes on filling the queue until it is full.
module grid_line_of_sight (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [5:0] cell_x,
  input  logic [5:0] cell_y,
  input  logic       cell_blocked,
  input  logic [5:0] from_x,
  input  logic [5:0] from_y,
  input  logic [5:0] to_x,
  input  logic [5:0] to_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       sight_clear
);

  glos_pkg::job_t in_job, q_job;
  logic           q_valid, q_take;

  // Classify: a write carries cell fields, a query its two tiles.
  always_comb begin
    in_job.command = glos_pkg::cmd_t'(command);
    in_job.blocked = cell_blocked;
    if (command == glos_pkg::CMD_WRITE) begin
      in_job.ax = cell_x; in_job.ay = cell_y;
      in_job.bx = '0;     in_job.by = '0;
    end else begin
      in_job.ax = from_x; in_job.ay = from_y;
      in_job.bx = to_x;   in_job.by = to_y;
    end
  end

  glos_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_job,
    .q_valid, .q_take, .q_job
  );

  glos_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_job,
    .out_valid, .out_stall, .sight_clear
  );

endmodule
